@@ hdl/u8l1_pkg.sv @@
// ----------------------------------------------------------------------------
// u8l1_pkg
// Shared types and constants for the UTF-8 to Latin-1 decoder.
// ----------------------------------------------------------------------------
package u8l1_pkg;

  localparam int unsigned CpW  = 31;
  localparam int unsigned CntW = 3;

  localparam logic [7:0] ReplaceReset = 8'hBF;

  // Result kind, carried on the output tuser
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_ERR  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  // Everything one input byte produces: some errors, then an optional
  // character, then an optional end-of-string marker.
  typedef struct packed {
    logic [CntW-1:0] n_err;
    logic            has_char;
    logic [CpW-1:0]  cp;
    logic            has_end;
    logic            str_ok;
  } job_t;

  // Smallest legal code point for a sequence of the given length
  function automatic logic [CpW-1:0] min_value(input logic [CntW-1:0] len);
    logic [CpW-1:0] v;
    begin
      case (len)
        3'd2:    v = 31'h0000_0080;
        3'd3:    v = 31'h0000_0800;
        3'd4:    v = 31'h0001_0000;
        3'd5:    v = 31'h0020_0000;
        3'd6:    v = 31'h0400_0000;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

@@ hdl/u8l1_decode.sv @@
// ----------------------------------------------------------------------------
// u8l1_decode
// Byte decoder: keeps the pending-sequence state and turns each accepted
// byte into a job register that lists the results it produces.
// ----------------------------------------------------------------------------
module u8l1_decode import u8l1_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_eos_i,
  input  logic       job_take_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  logic [CntW-1:0] need_q, need_d, len_q, len_d, seen_q, seen_d;
  logic [CpW-1:0]  acc_q, acc_d;
  logic            ok_q, ok_d;
  logic            job_valid_q, job_valid_d;
  job_t            job_q, job_d;

  logic            accept, pending, is_cont;
  logic [CntW-1:0] flush_n;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = ~job_valid_q | job_take_i;
  assign pending    = (need_q != '0);
  assign is_cont    = (in_byte_i[7:6] == 2'b10);
  assign flush_n    = pending ? seen_q + 3'd1 : 3'd0;

  always_comb begin
    need_d = need_q;
    len_d  = len_q;
    seen_d = seen_q;
    acc_d  = acc_q;
    job_d  = '0;

    if (in_byte_i == 8'h00) begin
      job_d.n_err   = flush_n;
      job_d.has_end = 1'b1;
      need_d = '0; len_d = '0; seen_d = '0; acc_d = '0;
    end else begin
      if (pending && is_cont) begin
        acc_d  = {acc_q[CpW-7:0], in_byte_i[5:0]};
        seen_d = seen_q + 3'd1;
        need_d = need_q - 3'd1;
        if (need_d == '0) begin
          if (acc_d >= min_value(len_q)) begin
            job_d.has_char = 1'b1;
            job_d.cp       = acc_d;
          end else begin
            job_d.n_err = 3'd1;
          end
          len_d = '0; seen_d = '0; acc_d = '0;
        end
      end else begin
        // drop whatever was pending, then decode this byte afresh
        job_d.n_err = flush_n;
        need_d = '0; len_d = '0; seen_d = '0; acc_d = '0;
        unique casez (in_byte_i)
          8'b0???????: begin
            job_d.has_char = 1'b1;
            job_d.cp       = {23'd0, in_byte_i};
          end
          8'b110?????: begin
            len_d = 3'd2; need_d = 3'd1; acc_d = {26'd0, in_byte_i[4:0]};
          end
          8'b1110????: begin
            len_d = 3'd3; need_d = 3'd2; acc_d = {27'd0, in_byte_i[3:0]};
          end
          8'b11110???: begin
            len_d = 3'd4; need_d = 3'd3; acc_d = {28'd0, in_byte_i[2:0]};
          end
          8'b111110??: begin
            len_d = 3'd5; need_d = 3'd4; acc_d = {29'd0, in_byte_i[1:0]};
          end
          8'b1111110?: begin
            len_d = 3'd6; need_d = 3'd5; acc_d = {30'd0, in_byte_i[0]};
          end
          8'b10??????, 8'b1111111?: begin
            job_d.n_err = flush_n + 3'd1;
          end
          default: begin
            job_d.n_err = flush_n + 3'd1;
          end
        endcase
      end
      if (in_eos_i) begin
        if (need_d != '0) begin
          job_d.n_err = job_d.n_err + seen_d + 3'd1;
        end
        job_d.has_end = 1'b1;
        need_d = '0; len_d = '0; seen_d = '0; acc_d = '0;
      end
    end

    job_d.str_ok = ok_q & (job_d.n_err == '0);

    if (job_d.has_end) begin
      ok_d = 1'b1;
    end else if (job_d.n_err != '0) begin
      ok_d = 1'b0;
    end else begin
      ok_d = ok_q;
    end

    if (accept) begin
      job_valid_d = (job_d.n_err != '0) | job_d.has_char | job_d.has_end;
    end else if (job_take_i) begin
      job_valid_d = 1'b0;
    end else begin
      job_valid_d = job_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q      <= '0;
      len_q       <= '0;
      seen_q      <= '0;
      acc_q       <= '0;
      ok_q        <= 1'b1;
      job_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      if (accept) begin
        need_q <= need_d;
        len_q  <= len_d;
        seen_q <= seen_d;
        acc_q  <= acc_d;
        ok_q   <= ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

@@ hdl/u8l1_emit.sv @@
// ----------------------------------------------------------------------------
// u8l1_emit
// Result sequencer: walks the current job one result per unstalled cycle
// into the output register, and holds the replacement byte register.
// ----------------------------------------------------------------------------
module u8l1_emit import u8l1_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           job_valid_i,
  input  job_t           job_i,
  output logic           job_take_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output kind_e          out_kind_o,
  output logic [CpW-1:0] out_cp_o,
  output logic [7:0]     out_latin1_o,
  output logic           out_str_ok_o,
  output logic           out_last_o
);

  logic [7:0]      repl_q;
  logic [CntW-1:0] errs_sent_q, errs_sent_d;
  logic            char_sent_q, char_sent_d;
  logic            out_valid_q, out_valid_d;
  kind_e           kind_q, kind_d;
  logic [CpW-1:0]  cp_q, cp_d;
  logic [7:0]      lat_q, lat_d;
  logic            sv_q, sv_d;
  logic            last_q, last_d;

  logic adv, emit;

  // the output register may load when empty or when its result leaves now
  assign adv  = ~out_valid_q | out_ready_i;
  assign emit = adv & job_valid_i;

  always_comb begin
    errs_sent_d = errs_sent_q;
    char_sent_d = char_sent_q;
    kind_d      = KIND_END;
    cp_d        = '0;
    lat_d       = '0;
    sv_d        = 1'b0;
    last_d      = 1'b1;
    if (errs_sent_q != job_i.n_err) begin
      kind_d      = KIND_ERR;
      lat_d       = repl_q;
      errs_sent_d = errs_sent_q + 3'd1;
      last_d      = (errs_sent_d == job_i.n_err) & ~job_i.has_char & ~job_i.has_end;
    end else if (job_i.has_char && !char_sent_q) begin
      kind_d      = KIND_CHAR;
      cp_d        = job_i.cp;
      lat_d       = (job_i.cp <= 31'd255) ? job_i.cp[7:0] : repl_q;
      char_sent_d = 1'b1;
      last_d      = ~job_i.has_end;
    end else begin
      sv_d = job_i.str_ok;
    end
    if (last_d) begin
      errs_sent_d = '0;
      char_sent_d = 1'b0;
    end
    out_valid_d = emit ? 1'b1 : (adv ? 1'b0 : out_valid_q);
  end

  assign job_take_o = emit & last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q      <= ReplaceReset;
      errs_sent_q <= '0;
      char_sent_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        repl_q <= cfg_wdata_i;
      end
      if (emit) begin
        errs_sent_q <= errs_sent_d;
        char_sent_q <= char_sent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      cp_q   <= cp_d;
      lat_q  <= lat_d;
      sv_q   <= sv_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = kind_q;
  assign out_cp_o     = cp_q;
  assign out_latin1_o = lat_q;
  assign out_str_ok_o = sv_q;
  assign out_last_o   = last_q;

endmodule

@@ hdl/utf8_decoder_latin1.sv @@
// ----------------------------------------------------------------------------
// utf8_decoder_latin1
// UTF-8 byte stream to code points with Latin-1 bytes and error reporting.
// ----------------------------------------------------------------------------
// One raw byte is taken per transfer on the slave side (tlast marks the last
// byte of a string, a zero byte also ends it). An accepted byte is registered
// as a job, and its results go one by one to the sequencer's output register.
// Every byte can be taken in the cycle after the previous one as long as it
// yields at most one result and the master side is not stalled; a byte with
// k results (errors from a broken sequence, a character, an end marker: k is
// at most 7) holds off the next byte until all k have left. Continuation
// bytes inside an unfinished sequence yield no transfer. The user must write
// the replacement byte register (cfg_we_i) only while idle; it is unenforced.
module utf8_decoder_latin1 import u8l1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // replace_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
  input  logic        s_axis_tlast,    // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [30:0] code_point, [38:31] latin1_out,
                                       // [39] string_valid
  output logic [1:0]  m_axis_tuser,    // [1:0] kind
  output logic        m_axis_tlast     // last_of_run
);

  job_t           job;
  logic           job_valid, job_take;
  kind_e          out_kind;
  logic [CpW-1:0] out_cp;
  logic [7:0]     out_lat;
  logic           out_sv;

  u8l1_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .job_take_i  (job_take),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  u8l1_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_take_o   (job_take),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (out_kind),
    .out_cp_o     (out_cp),
    .out_latin1_o (out_lat),
    .out_str_ok_o (out_sv),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_sv, out_lat, out_cp};
  assign m_axis_tuser = out_kind;

endmodule

@@ hdl/u8l1_checker.sv @@
// ----------------------------------------------------------------------------
// u8l1_checker
// Port-level checks on the decoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
module u8l1_checker import u8l1_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [7:0]  cfg_wdata_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // an end marker always closes the run of its byte
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
    else $error("end marker not last of run");

  // an error carries no code point and no valid flag
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERR |->
      m_axis_tdata[30:0] == '0 && !m_axis_tdata[39])
    else $error("error result with payload");

  // a character below 256 is its own Latin-1 byte
  a_char_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_CHAR && m_axis_tdata[30:8] == '0 |->
      m_axis_tdata[38:31] == m_axis_tdata[7:0] && !m_axis_tdata[39])
    else $error("latin-1 byte mismatch");

endmodule

bind utf8_decoder_latin1 u8l1_checker u_checker (.*);
